// ----- design/byns_pkg.sv -----
package byns_pkg;

	localparam int MAX_YEARS_DEF = 128;

	localparam int MONEY_W = 48;
	localparam int RATE_W  = 25;
	localparam int YEARS_W = 8;
	localparam int YIELD_W = 32;
	localparam int TOL_W   = 29;
	localparam int ITER_W  = 8;
	localparam int STAT_W  = 2;
	localparam int COUP_W  = 49;

	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 48;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int MUL_W  = 64;
	localparam int DIVN_W = 92;
	localparam int DIVD_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_GUESS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_TOLERANCE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT = 2'd2;

	localparam logic [STAT_W-1:0] ST_CONVERGED = 2'd0;
	localparam logic [STAT_W-1:0] ST_FLAT      = 2'd1;
	localparam logic [STAT_W-1:0] ST_LIMIT     = 2'd2;

	localparam logic [YIELD_W-1:0] INIT_GUESS_RST = 32'd13421773;
	localparam logic [TOL_W-1:0]   TOL_RST        = 29'd268;
	localparam logic [ITER_W-1:0]  ITER_LIMIT_RST = 8'd100;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

endpackage

// ----- design/byns_mul.sv -----
module byns_mul (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      sh24,
	input  logic [byns_pkg::MUL_W-1:0] a,
	input  logic [byns_pkg::MUL_W-1:0] b,
	output logic                      done,
	output logic [byns_pkg::MUL_W-1:0] res
);
	import byns_pkg::*;

	logic [2:0]   cnt_q;
	logic         busy_q;
	logic         sh24_q;
	logic [63:0]  a_q, b_q;
	logic [63:0]  pp_q;
	logic [1:0]   ppsel_q;
	logic [127:0] acc_q;
	logic [127:0] acc_next;
	logic [127:0] pp_ext;
	logic [31:0]  a_part, b_part;

	assign a_part = cnt_q[0] ? a_q[63:32] : a_q[31:0];
	assign b_part = cnt_q[1] ? b_q[63:32] : b_q[31:0];
	assign pp_ext = {64'd0, pp_q} << (7'd32 * {5'd0, ppsel_q});
	assign acc_next = acc_q + pp_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			b_q    <= b;
			sh24_q <= sh24;
			acc_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q != 3'd4) begin
				pp_q    <= a_part * b_part;
				ppsel_q <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
			end
			// accumulate the previous partial product
			if (cnt_q != 3'd0)
				acc_q <= acc_next;
			if (cnt_q == 3'd4) begin
				if (sh24_q)
					res <= (acc_next[127:88] != '0) ? {64{1'b1}} : acc_next[87:24];
				else
					res <= (acc_next[127:96] != '0) ? {64{1'b1}} : acc_next[95:32];
			end
		end
	end

endmodule

// ----- design/byns_div.sv -----
module byns_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [byns_pkg::DIVN_W-1:0] num,
	input  logic [byns_pkg::DIVD_W-1:0] den,
	output logic                       done,
	output logic [byns_pkg::DIVN_W-1:0] quot
);
	import byns_pkg::*;

	localparam int CW = $clog2(DIVN_W + 1);

	logic              busy_q;
	logic [CW-1:0]     cnt_q;
	logic [DIVD_W-1:0] den_q;
	logic [DIVD_W-1:0] rem_q;
	logic [DIVD_W:0]   rr;
	logic [DIVD_W:0]   diff;
	logic              qbit;

	assign rr   = {rem_q, quot[DIVN_W-1]};
	assign diff = rr - {1'b0, den_q};
	assign qbit = rr >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIVN_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quot  <= num;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DIVD_W-1:0] : rr[DIVD_W-1:0];
			quot  <= {quot[DIVN_W-2:0], qbit};
		end
	end

endmodule

// ----- design/bond_yield_newton_solver.sv -----
// Yield to maturity solver, Newton-Raphson on one shared 64x64 multiplier and one divider.
// Each iteration runs two divisions and, over Y years, three products per year on the multiplier,
// two more for the face value.
// Throughput: one request at a time; the next is taken while a result waits at the output.
// Reset (arst_n low, asynchronous): registers return to 0.05, about 1e-6 and 100, no result held.
module bond_yield_newton_solver #(
	parameter int MAX_YEARS = byns_pkg::MAX_YEARS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// face_value, coupon_rate, years_to_maturity, market_price, zero pad
	input  logic [byns_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// yield_estimate, finish_status, iterations_used, zero pad
	output logic [byns_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [byns_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [byns_pkg::CFG_DATA_W-1:0] cfg_data
);
	import byns_pkg::*;

	localparam int TW = $clog2(MAX_YEARS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_COUP, S_CHECK, S_DDIV, S_PN, S_CP, S_CD, S_FP, S_FD, S_EVAL, S_RDIV, S_FIN
	} state_t;

	state_t state_q;

	logic signed [YIELD_W-1:0] guess_q;
	logic [TOL_W-1:0]          tol_q;
	logic [ITER_W-1:0]         limit_q;

	logic [MONEY_W-1:0] face_q, market_q;
	logic [TW-1:0]      years_q, t_q;
	logic [63:0]        coupon_q, d_q, p_q, pn_q, price_q, deriv_q;
	logic signed [YIELD_W-1:0] y_q;
	logic [ITER_W-1:0]  it_q;
	logic [STAT_W-1:0]  stat_q;
	logic               above_q;

	logic               mul_start, mul_sh24, mul_done;
	logic [63:0]        mul_a, mul_b, mul_res;
	logic               div_start, div_done;
	logic [DIVN_W-1:0]  div_num, div_quot;
	logic [DIVD_W-1:0]  div_den;

	logic [MONEY_W-1:0] in_face, in_market;
	logic [RATE_W-1:0]  in_rate;
	logic [YEARS_W-1:0] in_years;

	logic signed [32:0] onep;
	logic [COUP_W+TW-1:0] scaled;
	logic               above;
	logic [63:0]        mag;
	logic [36:0]        step;
	logic signed [39:0] ny_wide;
	logic signed [YIELD_W-1:0] ny;
	logic signed [33:0] dy;
	logic [33:0]        delta;

	assign in_face   = s_axis_tdata[47:0];
	assign in_rate   = s_axis_tdata[72:48];
	assign in_years  = s_axis_tdata[80:73];
	assign in_market = s_axis_tdata[128:81];

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;

	assign onep   = 33'sd268435456 + 33'(y_q);
	assign scaled = ((state_q == S_CP) ? COUP_W'(coupon_q) : COUP_W'(face_q)) * t_q;
	assign above  = price_q >= {16'd0, market_q};
	assign mag    = above ? price_q - {16'd0, market_q} : {16'd0, market_q} - price_q;
	assign step   = (div_quot[DIVN_W-1:36] != '0) ? 37'h10_0000_0000 : div_quot[36:0];
	assign ny_wide = above_q ? 40'(y_q) + $signed({3'd0, step}) : 40'(y_q) - $signed({3'd0, step});
	always_comb begin
		if (ny_wide > 40'sd2147483647)
			ny = 32'sh7FFF_FFFF;
		else if (ny_wide < -40'sd2147483648)
			ny = 32'sh8000_0000;
		else
			ny = ny_wide[31:0];
		dy    = 34'(ny) - 34'(y_q);
		delta = dy[33] ? -dy : dy;
	end

	always_comb begin
		mul_start = 1'b0;
		mul_sh24  = 1'b0;
		mul_a     = p_q;
		mul_b     = d_q;
		div_start = 1'b0;
		div_num   = {mag, 28'd0};
		div_den   = deriv_q;
		case (state_q)
			S_IDLE: begin
				mul_start = s_axis_tvalid;
				mul_sh24  = 1'b1;
				mul_a     = {16'd0, in_face};
				mul_b     = {39'd0, in_rate};
			end
			S_CHECK: begin
				div_start = (it_q < limit_q) && (onep > 33'sd0);
				div_num   = DIVN_W'(64'h1000_0000_0000_0000);
				div_den   = 64'(onep[31:0]);
			end
			S_DDIV: begin
				mul_start = div_done && (years_q != '0);
				mul_a     = div_quot[63:0];
				mul_b     = div_quot[63:0];
			end
			S_PN: begin
				mul_start = mul_done;
				mul_a     = coupon_q;
				mul_b     = p_q;
			end
			S_CP: begin
				mul_start = mul_done;
				mul_a     = 64'(scaled);
				mul_b     = pn_q;
			end
			S_CD: begin
				mul_start = mul_done && (t_q == years_q);
				mul_a     = {16'd0, face_q};
				mul_b     = p_q;
			end
			S_FP: begin
				mul_start = mul_done;
				mul_a     = 64'(scaled);
				mul_b     = pn_q;
			end
			S_EVAL: div_start = (deriv_q != '0);
			default: ;
		endcase
		if ((state_q == S_CD && t_q != years_q) || state_q == S_FD) begin
			// next year starts from the new power of the discount
			mul_start = mul_done && (state_q == S_CD || state_q == S_FD) && (t_q != years_q);
			mul_a     = pn_q;
			mul_b     = d_q;
		end
	end

	byns_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.sh24  (mul_sh24),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.res   (mul_res)
	);

	byns_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			guess_q       <= INIT_GUESS_RST;
			tol_q         <= TOL_RST;
			limit_q       <= ITER_LIMIT_RST;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_INITIAL_GUESS:   guess_q <= cfg_data;
					REG_STEP_TOLERANCE:  tol_q   <= cfg_data[TOL_W-1:0];
					REG_ITERATION_LIMIT: limit_q <= cfg_data[ITER_W-1:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready && state_q != S_FIN)
				m_axis_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						face_q   <= in_face;
						market_q <= in_market;
						if (32'(in_years) > MAX_YEARS)
							years_q <= TW'(MAX_YEARS);
						else
							years_q <= TW'(in_years);
						y_q     <= guess_q;
						it_q    <= '0;
						state_q <= S_COUP;
					end
				end
				S_COUP: begin
					if (mul_done) begin
						coupon_q <= mul_res;
						state_q  <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (it_q >= limit_q) begin
						stat_q  <= ST_LIMIT;
						state_q <= S_FIN;
					end else begin
						it_q <= it_q + 1'b1;
						if (onep <= 33'sd0) begin
							stat_q  <= ST_FLAT;
							state_q <= S_FIN;
						end else begin
							state_q <= S_DDIV;
						end
					end
				end
				S_DDIV: begin
					if (div_done) begin
						d_q     <= div_quot[63:0];
						p_q     <= div_quot[63:0];
						price_q <= (years_q == '0) ? {16'd0, face_q} : 64'd0;
						deriv_q <= '0;
						t_q     <= TW'(1);
						state_q <= (years_q == '0) ? S_EVAL : S_PN;
					end
				end
				S_PN: begin
					if (mul_done) begin
						pn_q    <= mul_res;
						state_q <= S_CP;
					end
				end
				S_CP: begin
					if (mul_done) begin
						price_q <= sat_add(price_q, mul_res);
						state_q <= S_CD;
					end
				end
				S_CD: begin
					if (mul_done) begin
						deriv_q <= sat_add(deriv_q, mul_res);
						if (t_q == years_q) begin
							state_q <= S_FP;
						end else begin
							p_q     <= pn_q;
							t_q     <= t_q + 1'b1;
							state_q <= S_PN;
						end
					end
				end
				S_FP: begin
					if (mul_done) begin
						price_q <= sat_add(price_q, mul_res);
						state_q <= S_FD;
					end
				end
				S_FD: begin
					if (mul_done) begin
						deriv_q <= sat_add(deriv_q, mul_res);
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					above_q <= above;
					if (deriv_q == '0) begin
						stat_q  <= ST_FLAT;
						state_q <= S_FIN;
					end else begin
						state_q <= S_RDIV;
					end
				end
				S_RDIV: begin
					if (div_done) begin
						y_q <= ny;
						if (delta < 34'(tol_q)) begin
							stat_q  <= ST_CONVERGED;
							state_q <= S_FIN;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_FIN: begin
					// hold until the output register is free
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= {6'd0, it_q, stat_q, y_q};
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import byns_pkg::*;

	localparam int  TB_MAX_YEARS = MAX_YEARS_DEF;
	localparam int  CYCLE_LIMIT  = 20000000;

	typedef struct packed {
		logic [ITER_W-1:0]  iterations_used;
		logic [STAT_W-1:0]  finish_status;
		logic [YIELD_W-1:0] yield_estimate;
	} solution_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// face_value, coupon_rate, years_to_maturity, market_price, zero pad
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// yield_estimate, finish_status, iterations_used, zero pad
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// model copy of the configuration registers
	longint          guess_q = longint'(signed'(INIT_GUESS_RST));
	logic [TOL_W-1:0]  tol_q = TOL_RST;
	logic [ITER_W-1:0] limit_q = ITER_LIMIT_RST;

	solution_t pending_solutions[$];
	int        errors = 0;
	int        cycles = 0;
	bit        quiet = 1'b0;
	int        stall_left = 0;

	bond_yield_newton_solver i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// saturating floor(a*b / 2^sh)
	function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int sh);
		logic [127:0] pr;
		pr = ({64'd0, a} * {64'd0, b}) >> sh;
		return (pr[127:64] != 0) ? {64{1'b1}} : pr[63:0];
	endfunction

	function automatic solution_t solve_yield(logic [MONEY_W-1:0] face, logic [RATE_W-1:0] rate,
			logic [YEARS_W-1:0] yrs_in, logic [MONEY_W-1:0] market);
		longint     y, ny, onep;
		logic [63:0] d, p, pn, price, deriv, mag, step, delta, coupon, yrs;
		logic [91:0] num;
		int         it;
		logic [STAT_W-1:0] st;
		bit         above;
		solution_t  r;
		y = guess_q;
		yrs = (yrs_in > TB_MAX_YEARS) ? 64'(TB_MAX_YEARS) : 64'(yrs_in);
		coupon = scaled_product(64'(face), 64'(rate), 24);
		it = 0;
		st = ST_LIMIT;
		while (it < limit_q) begin
			it++;
			onep = (longint'(1) << 28) + y;
			if (onep <= 0) begin
				st = ST_FLAT;
				break;
			end
			d = (64'd1 << 60) / 64'(onep);
			p = d;
			price = (yrs == 0) ? 64'(face) : 64'd0;
			deriv = 0;
			for (longint t = 1; t <= yrs; t++) begin
				pn = scaled_product(p, d, 32);
				price = sat_add(price, scaled_product(coupon, p, 32));
				deriv = sat_add(deriv, scaled_product(coupon * t, pn, 32));
				if (t == yrs) begin
					price = sat_add(price, scaled_product(64'(face), p, 32));
					deriv = sat_add(deriv, scaled_product(64'(face) * yrs, pn, 32));
				end
				p = pn;
			end
			if (deriv == 0) begin
				st = ST_FLAT;
				break;
			end
			above = price >= 64'(market);
			mag = above ? price - 64'(market) : 64'(market) - price;
			if (mag / deriv >= 256) begin
				step = 64'd1 << 36;
			end else begin
				num = {mag, 28'd0};
				step = 64'(num / deriv);
				if (step > (64'd1 << 36)) step = 64'd1 << 36;
			end
			ny = above ? y + longint'(step) : y - longint'(step);
			if (ny > 64'sh7FFF_FFFF) ny = 64'sh7FFF_FFFF;
			if (ny < -64'sh8000_0000) ny = -64'sh8000_0000;
			delta = (ny >= y) ? ny - y : y - ny;
			y = ny;
			if (delta < 64'(tol_q)) begin
				st = ST_CONVERGED;
				break;
			end
		end
		r.yield_estimate = y[31:0];
		r.finish_status = st;
		r.iterations_used = it[7:0];
		return r;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_INITIAL_GUESS:   guess_q = longint'(signed'(value));
			REG_STEP_TOLERANCE:  tol_q = value[TOL_W-1:0];
			REG_ITERATION_LIMIT: limit_q = value[ITER_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_bond(logic [MONEY_W-1:0] face, logic [RATE_W-1:0] rate,
			logic [YEARS_W-1:0] yrs, logic [MONEY_W-1:0] market);
		if (!quiet && $urandom_range(0, 2) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, market, yrs, rate, face};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_solutions.push_back(solve_yield(face, rate, yrs, market));
	endtask

	// hold off until every solution is back
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_solutions.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [MONEY_W-1:0] rand_money();
		return MONEY_W'({$urandom(), $urandom()});
	endfunction

	task automatic send_sane_bond(int max_years);
		logic [MONEY_W-1:0] face;
		logic [63:0]        market;
		face = (MONEY_W'($urandom_range(100, 10000)) << 16) | MONEY_W'($urandom_range(0, 65535));
		market = (64'(face) * $urandom_range(700, 1300)) / 1000;
		send_bond(face, RATE_W'($urandom_range(0, 2516582)),
			YEARS_W'($urandom_range(1, max_years)), market[47:0]);
	endtask

	task automatic test_directed_edges;
		send_bond(48'd100 << 16, 25'd838861, 8'd5, 48'd95 << 16);
		send_bond(48'd1000 << 16, 25'd0, 8'd1, 48'd900 << 16);
		send_bond(48'd1000 << 16, 25'd838861, 8'd0, 48'd1000 << 16);
		send_bond(48'd0, 25'd0, 8'd10, 48'd0);
		send_bond(48'd1000 << 16, 25'd1 << 24, 8'd3, 48'd1500 << 16);
		send_bond(48'd1000 << 16, 25'h1FF_FFFF, 8'd2, 48'd1000 << 16);
		send_bond(48'd1000 << 16, 25'd838861, 8'd128, 48'd1000 << 16);
		send_bond(48'd1000 << 16, 25'd838861, 8'd255, 48'd1000 << 16);
		send_bond(48'd500 << 16, 25'd419430, 8'd7, {MONEY_W{1'b1}});
		drain();
		// saturating sums, kept short by the limit
		write_reg(REG_ITERATION_LIMIT, 32'd3);
		send_bond({MONEY_W{1'b1}}, 25'h1FF_FFFF, 8'd4, 48'd0);
		send_bond({MONEY_W{1'b1}}, 25'h1FF_FFFF, 8'd128, {MONEY_W{1'b1}});
		send_bond(48'd1, 25'd1, 8'd1, 48'd0);
		drain();
	endtask

	task automatic test_config_extremes;
		write_reg(REG_ITERATION_LIMIT, 32'd0);
		send_bond(48'd100 << 16, 25'd838861, 8'd5, 48'd95 << 16);
		drain();
		write_reg(REG_ITERATION_LIMIT, 32'd1);
		write_reg(REG_INITIAL_GUESS, 32'h8000_0000);
		send_bond(48'd100 << 16, 25'd838861, 8'd5, 48'd95 << 16);
		drain();
		write_reg(REG_INITIAL_GUESS, 32'hF000_0000);
		send_bond(48'd100 << 16, 25'd838861, 8'd5, 48'd95 << 16);
		drain();
		write_reg(REG_ITERATION_LIMIT, 32'd4);
		write_reg(REG_INITIAL_GUESS, 32'h7FFF_FFFF);
		send_bond(48'd100 << 16, 25'd838861, 8'd5, 48'd95 << 16);
		drain();
		write_reg(REG_INITIAL_GUESS, 32'hF000_0001);
		send_bond(48'd100 << 16, 25'd838861, 8'd3, 48'd150 << 16);
		drain();
		write_reg(REG_INITIAL_GUESS, 32'd13421773);
		write_reg(REG_STEP_TOLERANCE, 32'd0);
		send_bond(48'd100 << 16, 25'd838861, 8'd5, 48'd95 << 16);
		drain();
		write_reg(REG_STEP_TOLERANCE, 32'd1 << 28);
		send_bond(48'd100 << 16, 25'd838861, 8'd5, 48'd95 << 16);
		drain();
		write_reg(REG_STEP_TOLERANCE, 32'h1FFF_FFFF);
		send_bond(48'd100 << 16, 25'd838861, 8'd5, 48'd80 << 16);
		drain();
		write_reg(REG_ITERATION_LIMIT, 32'd255);
		write_reg(REG_STEP_TOLERANCE, 32'd268);
		send_bond(48'd100 << 16, 25'd838861, 8'd6, 48'd90 << 16);
		drain();
	endtask

	task automatic test_random_bonds;
		write_reg(REG_ITERATION_LIMIT, 32'd40);
		for (int ph = 0; ph < 3; ph++) begin
			write_reg(REG_INITIAL_GUESS, $urandom_range(0, 50000000));
			write_reg(REG_STEP_TOLERANCE, $urandom_range(1, 4000));
			for (int k = 0; k < 20; k++) send_sane_bond(12);
			drain();
		end
	endtask

	task automatic test_random_noise;
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_ITERATION_LIMIT, $urandom_range(1, 6));
			write_reg(REG_INITIAL_GUESS, $urandom());
			write_reg(REG_STEP_TOLERANCE, $urandom() & 32'h1FFF_FFFF);
			for (int k = 0; k < 8; k++)
				send_bond(rand_money(), RATE_W'($urandom()), YEARS_W'($urandom_range(0, 255)),
					rand_money());
			drain();
		end
	endtask

	task automatic test_back_to_back;
		quiet = 1'b1;
		write_reg(REG_ITERATION_LIMIT, 32'd100);
		write_reg(REG_INITIAL_GUESS, 32'd13421773);
		write_reg(REG_STEP_TOLERANCE, 32'd268);
		for (int k = 0; k < 10; k++) send_sane_bond(8);
		drain();
	endtask

	always @(posedge clk) begin
		if (quiet) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left <= $urandom_range(0, 4);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		solution_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[41:0];
			if (pending_solutions.size() == 0) begin
				$error("unexpected result %h", m_axis_tdata);
				errors++;
			end else begin
				want = pending_solutions.pop_front();
				if (got.yield_estimate !== want.yield_estimate) begin
					$error("yield_estimate expected %h actual %h",
						want.yield_estimate, got.yield_estimate);
					errors++;
				end
				if (got.finish_status !== want.finish_status) begin
					$error("finish_status expected %0d actual %0d",
						want.finish_status, got.finish_status);
					errors++;
				end
				if (got.iterations_used !== want.iterations_used) begin
					$error("iterations_used expected %0d actual %0d",
						want.iterations_used, got.iterations_used);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_config_extremes();
		test_random_bonds();
		test_random_noise();
		test_back_to_back();
		if (errors == 0 && pending_solutions.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
